// ===== hdl/mppt_perturb_observe_controller_macros.svh =====
// Assertion helpers for the MPPT controller.
`ifndef MPPT_PERTURB_OBSERVE_CONTROLLER_MACROS_SVH
`define MPPT_PERTURB_OBSERVE_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define MPPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define MPPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mppt_pkg.sv =====
`timescale 1ns / 1ps

package mppt_pkg;

  // Duty limits and tracking pace
  localparam logic [15:0] MIN_DUTY   = 16'd100;
  localparam logic [15:0] MAX_DUTY   = 16'd3995;
  localparam logic [15:0] EXEC_TICKS = 16'd100;

  // Fixed-point thresholds
  localparam logic [63:0] POWER_FLOOR = 64'd10 << 32;
  localparam logic [63:0] POWER_BAND  = 64'd4 << 32;
  localparam logic [31:0] HYST_VOLTS  = 32'd327680;
  localparam logic [15:0] LOW_POWER_DROP = 16'd10;
  localparam logic [16:0] Q16_ONE     = 17'd65536;

  // Current sensor scaling: code * 3.3 * 65536 / 65535, rounded.
  // With n = 33 * code the sensor value is (n + 5 + n / 65535) / 10, the last
  // division done as a multiply by ceil(2^26 / 10) and a shift by 26.
  localparam logic [22:0] SENSOR_BIAS  = 23'd5;
  localparam logic [31:0] SENSOR_RECIP = 32'd6710887;

  // Mode codes
  localparam logic [1:0] MODE_BOOT  = 2'd0;
  localparam logic [1:0] MODE_TRACK = 2'd1;
  localparam logic [1:0] MODE_FAULT = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_SCALE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_OFFSET = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OVER_VOLTAGE   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OVER_CURRENT   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_IN         = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY       = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP      = 4'd7;

  // Input item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] voltage_code;
    logic [15:0] current_code;
  } in_item_t;

  typedef struct packed {
    logic [15:0] duty_value;
    logic [1:0]  mode;
    logic        trip_active;
    logic        brake_relay;
    logic [31:0] voltage_filtered;
    logic [31:0] current_filtered;
  } out_item_t;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_VMUL   = 12'b0000_0000_0010,
    ST_DIV    = 12'b0000_0000_0100,
    ST_VS_A   = 12'b0000_0000_1000,
    ST_VS_B   = 12'b0000_0001_0000,
    ST_IS_A   = 12'b0000_0010_0000,
    ST_IS_B   = 12'b0000_0100_0000,
    ST_CHECK  = 12'b0000_1000_0000,
    ST_TICK   = 12'b0001_0000_0000,
    ST_POWER  = 12'b0010_0000_0000,
    ST_TRACK  = 12'b0100_0000_0000,
    ST_FINISH = 12'b1000_0000_0000
  } state_t;

endpackage

// ===== hdl/mppt_perturb_observe_controller.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Ports                        | Transaction
// input    | in        | in_valid, in_stall, in_data  | in_valid & !in_stall
// result   | out       | out_valid, out_stall, out_data | out_valid & !out_stall
// config   | in        | cfg_wr_en, cfg_index, cfg_wr_data | cfg_wr_en
//
// After acceptance a sample runs one scale multiply, one reciprocal multiply
// for the current sensor, four filter multiplies on the single shared 32x32
// multiplier, one limit check and the output load. A tick runs its own step,
// then a tracking step when one is due (power multiply, then decision), then
// the output load. The next input can be taken in the cycle after the load.
// Reset (rst_n low, synchronous) restores register defaults and boot state.
// in_stall stays high until the result is handed to the output register; a
// stalled result holds while the next item is already taken.
`include "mppt_perturb_observe_controller_macros.svh"

module mppt_perturb_observe_controller
  import mppt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wr_data
);

  // Configuration
  logic [15:0] voltage_scale_r;
  logic [17:0] current_offset_r;
  logic [16:0] filter_alpha_r;
  logic [31:0] over_voltage_r, over_current_r, cut_in_r, recovery_r;
  logic [11:0] slew_step_r;

  // Controller state
  state_t      state_r, state_nxt;
  logic [1:0]  mode_r;
  logic [15:0] pacing_r;
  logic [31:0] vs_r, cs_r, last_v_r;
  logic [63:0] power_r, last_power_r;
  logic [15:0] duty_r;
  logic        trip_r, relay_r;

  // Datapath
  in_item_t    item_r;
  logic [31:0] vraw_r, iraw_r;
  logic [49:0] acc_r;
  logic [17:0] sensor_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [16:0] alpha_eff, alpha_inv;
  logic [49:0] acc_sum;
  logic [21:0] icode_x33;
  logic [22:0] wrap_sum, sensor_y;
  logic [17:0] sensor, sensor_diff;
  logic [15:0] pacing_inc;
  logic        rise, fall, v_up, low_hyst;
  logic signed [17:0] duty_try, duty_clamped;
  logic        in_accept, out_free;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Filter weights, saturating alpha at one
  assign alpha_eff = (filter_alpha_r > Q16_ONE) ? Q16_ONE : filter_alpha_r;
  assign alpha_inv = Q16_ONE - alpha_eff;

  // Select shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_VMUL: begin
        mul_a = {16'd0, item_r.voltage_code};
        mul_b = {16'd0, voltage_scale_r};
      end
      ST_DIV: begin
        mul_a = {9'd0, sensor_y};
        mul_b = SENSOR_RECIP;
      end
      ST_VS_A: begin
        mul_a = vraw_r;
        mul_b = {15'd0, alpha_eff};
      end
      ST_VS_B: begin
        mul_a = vs_r;
        mul_b = {15'd0, alpha_inv};
      end
      ST_IS_A: begin
        mul_a = iraw_r;
        mul_b = {15'd0, alpha_eff};
      end
      ST_IS_B: begin
        mul_a = cs_r;
        mul_b = {15'd0, alpha_inv};
      end
      ST_POWER: begin
        mul_a = vs_r;
        mul_b = cs_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign acc_sum = acc_r + prod[49:0];

  // Sensor voltage: n = 33 * code, dividend n + 5 + n / 65535, then divide by ten
  assign icode_x33 = {1'b0, item_r.current_code, 5'd0} + {6'd0, item_r.current_code};
  assign wrap_sum  = {1'b0, icode_x33} + {17'd0, icode_x33[21:16]} + 23'd1;
  assign sensor_y  = {1'b0, icode_x33} + SENSOR_BIAS + {17'd0, wrap_sum[21:16]};

  // Current from sensor voltage: (sensor - offset) / 0.040, floored at zero
  assign sensor      = sensor_r;
  assign sensor_diff = sensor - current_offset_r;

  // Tracking decision
  assign pacing_inc = pacing_r + 16'd1;
  assign v_up = (vs_r > last_v_r);
  assign rise = (power_r > last_power_r) && ((power_r - last_power_r) > POWER_BAND);
  assign fall = (last_power_r > power_r) && ((last_power_r - power_r) > POWER_BAND);
  assign low_hyst = (cut_in_r >= HYST_VOLTS) && (vs_r < (cut_in_r - HYST_VOLTS));

  always_comb begin
    duty_try = $signed({2'b00, duty_r});
    if (power_r > POWER_FLOOR) begin
      if ((rise && v_up) || (fall && !v_up)) begin
        duty_try = $signed({2'b00, duty_r}) - $signed({6'd0, slew_step_r});
      end else if (rise || fall) begin
        duty_try = $signed({2'b00, duty_r}) + $signed({6'd0, slew_step_r});
      end
    end else begin
      duty_try = $signed({2'b00, duty_r}) - $signed({2'b00, LOW_POWER_DROP});
    end
    duty_clamped = duty_try;
    if (duty_clamped > $signed({2'b00, MAX_DUTY})) duty_clamped = $signed({2'b00, MAX_DUTY});
    if (duty_clamped < $signed({2'b00, MIN_DUTY})) duty_clamped = $signed({2'b00, MIN_DUTY});
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_accept) state_nxt = (in_data.kind == KIND_TICK) ? ST_TICK : ST_VMUL;
      ST_VMUL:  state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_VS_A;
      ST_VS_A:  state_nxt = ST_VS_B;
      ST_VS_B:  state_nxt = ST_IS_A;
      ST_IS_A:  state_nxt = ST_IS_B;
      ST_IS_B:  state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = ST_FINISH;
      ST_TICK: begin
        if (mode_r == MODE_TRACK && pacing_inc >= EXEC_TICKS) state_nxt = ST_POWER;
        else state_nxt = ST_FINISH;
      end
      ST_POWER:  state_nxt = ST_TRACK;
      ST_TRACK:  state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      voltage_scale_r  <= 16'd1;
      current_offset_r <= 18'd108136;
      filter_alpha_r   <= 17'd6554;
      over_voltage_r   <= 32'd3932160;
      over_current_r   <= 32'd2621440;
      cut_in_r         <= 32'd983040;
      recovery_r       <= 32'd3276800;
      slew_step_r      <= 12'd10;
      mode_r           <= MODE_BOOT;
      pacing_r         <= '0;
      vs_r             <= '0;
      cs_r             <= '0;
      last_power_r     <= '0;
      last_v_r         <= '0;
      duty_r           <= MIN_DUTY;
      trip_r           <= 1'b0;
      relay_r          <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Apply configuration writes; unknown indexes drop
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_VOLTAGE_SCALE:  voltage_scale_r  <= cfg_wr_data[15:0];
          REG_CURRENT_OFFSET: current_offset_r <= cfg_wr_data[17:0];
          REG_FILTER_ALPHA:   filter_alpha_r   <= cfg_wr_data[16:0];
          REG_OVER_VOLTAGE:   over_voltage_r   <= cfg_wr_data;
          REG_OVER_CURRENT:   over_current_r   <= cfg_wr_data;
          REG_CUT_IN:         cut_in_r         <= cfg_wr_data;
          REG_RECOVERY:       recovery_r       <= cfg_wr_data;
          REG_SLEW_STEP:      slew_step_r      <= cfg_wr_data[11:0];
          default: ;
        endcase
      end

      // Load a new result, else retire the output transaction
      if (state_r == ST_FINISH && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      case (state_r)
        ST_VS_B: vs_r <= acc_sum[47:16];
        ST_IS_B: cs_r <= acc_sum[47:16];
        ST_CHECK: begin
          if (vs_r >= over_voltage_r || cs_r >= over_current_r) begin
            mode_r <= MODE_FAULT;
            trip_r <= 1'b1;
          end
        end
        ST_TICK: begin
          case (mode_r)
            MODE_BOOT: begin
              relay_r <= 1'b0;
              duty_r  <= MIN_DUTY;
              if (vs_r >= cut_in_r) begin
                mode_r   <= MODE_TRACK;
                pacing_r <= '0;
              end
            end
            MODE_TRACK: begin
              pacing_r <= (pacing_inc >= EXEC_TICKS) ? 16'd0 : pacing_inc;
            end
            MODE_FAULT: begin
              relay_r <= 1'b1;
              duty_r  <= MIN_DUTY;
              if (vs_r < recovery_r) begin
                trip_r <= 1'b0;
                mode_r <= MODE_BOOT;
              end
            end
            default: mode_r <= MODE_BOOT;
          endcase
        end
        ST_TRACK: begin
          duty_r       <= duty_clamped[15:0];
          last_power_r <= power_r;
          last_v_r     <= vs_r;
          if (!(power_r > POWER_FLOOR) && low_hyst) mode_r <= MODE_BOOT;
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) item_r <= in_data;
    case (state_r)
      ST_VMUL: vraw_r <= prod[31:0];
      // Quotient of the reciprocal multiply fits in 18 bits
      ST_DIV:  sensor_r <= prod[43:26];
      ST_VS_A: begin
        acc_r  <= prod[49:0] + 50'd32768;
        iraw_r <= (sensor > current_offset_r) ?
                  {9'd0, sensor_diff, 5'd0} - {11'd0, sensor_diff, 3'd0}
                  + {14'd0, sensor_diff} : 32'd0;
      end
      ST_IS_A:  acc_r <= prod[49:0] + 50'd32768;
      ST_POWER: power_r <= prod;
      ST_FINISH: begin
        if (out_free) begin
          out_r.duty_value       <= duty_r;
          out_r.mode             <= mode_r;
          out_r.trip_active      <= trip_r;
          out_r.brake_relay      <= relay_r;
          out_r.voltage_filtered <= vs_r;
          out_r.current_filtered <= cs_r;
        end
      end
      default: ;
    endcase
  end

  // Duty always sits inside its limits
  `MPPT_ASSERT_IMP(a_duty_range, 1'b1, duty_r >= MIN_DUTY && duty_r <= MAX_DUTY, "duty out of range")
  // Trip flag only in fault mode
  `MPPT_ASSERT_IMP(a_trip_fault, trip_r, mode_r == MODE_FAULT, "trip outside fault")
  // An accepted transaction starts the sequencer
  `MPPT_ASSERT_NXT(a_accept_busy, in_accept, state_r != ST_IDLE, "accept left sequencer idle")

endmodule
